FILE: sv/cdq_pkg.sv
// shared types and constants for the circular deque with search
`default_nettype none

package cdq_pkg;

  // ring depth; position and occupancy fields are sized to hold it
  localparam int DEPTH    = 16;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;
  localparam int OCC_W    = 5;
  localparam int TDATA_W  = 48;
  localparam int PAD_W    = TDATA_W - VALUE_W - POS_W - OCC_W;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_READ = 5'b00100,
    S_SRCH = 5'b01000,
    S_DONE = 5'b10000
  } cdq_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd_en;
    logic push;
    logic pop_commit;
    logic srch_step;
    logic res_plain;
    logic emit;
  } cdq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic is_search;
    logic full;
    logic empty;
    logic hit;
    logic last;
    logic out_free;
  } cdq_stat_t;

endpackage

`default_nettype wire

FILE: sv/cdq_ram.sv
// generic single-write, single-read memory with registered read data
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/cdq_ctrl.sv
// controller state machine for the circular deque
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire cdq_stat_t stat,
  output cdq_cmd_t       cmd
);

  cdq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_pop && !stat.empty) begin
          cmd.rd_en  = 1'b1;
          state_next = S_READ;
        end else if (stat.is_search && !stat.empty) begin
          cmd.rd_en  = 1'b1;
          state_next = S_SRCH;
        end else begin
          // pushes, refused items and unused kinds finish here
          cmd.res_plain = 1'b1;
          cmd.push      = stat.is_push && !stat.full;
          state_next    = S_DONE;
        end
      end
      S_READ: begin
        cmd.pop_commit = 1'b1;
        state_next     = S_DONE;
      end
      S_SRCH: begin
        cmd.srch_step = 1'b1;
        cmd.rd_en     = 1'b1;
        if (stat.hit || stat.last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_EXEC))
    else $error("accepted request did not enter execution");

  a_search_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH && (stat.hit || stat.last)) |=> (state == S_DONE))
    else $error("search did not finish on match or last entry");

  a_one_cmd_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (stat.out_free && !cmd.load && !cmd.push))
    else $error("result emitted into a busy output register");

endmodule

`default_nettype wire

FILE: sv/cdq_dpath.sv
// datapath: ring pointers, entry store, search compare and output register
`default_nettype none

module cdq_dpath
  import cdq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cdq_cmd_t            cmd,
  output cdq_stat_t                stat,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [VALUE_W-1:0]  in_value,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [TDATA_W-1:0]       m_tdata,
  output logic [STATUS_W-1:0]      m_tuser
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  // base plus offset, wrapped into the ring; offset never exceeds the depth
  function automatic logic [AW-1:0] ring(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [KIND_W-1:0]   kind;
  logic [VALUE_W-1:0]  value;
  logic [AW-1:0]       front;
  logic [CW-1:0]       count;
  logic [CW-1:0]       cmp_idx;
  logic [STATUS_W-1:0] res_status;
  logic [VALUE_W-1:0]  res_value;
  logic [CW-1:0]       res_pos;
  logic [VALUE_W-1:0]  out_value;
  logic [POS_W-1:0]    out_pos;
  logic [OCC_W-1:0]    out_occ;
  logic [STATUS_W-1:0] out_status;

  logic [AW-1:0]       front_m1;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic [CW-1:0]       rd_off;
  logic [VALUE_W-1:0]  rdata;

  assign front_m1 = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign wr_addr  = (kind == KIND_PUSH_FRONT) ? front_m1 : ring(front, count);
  // search fetches one entry ahead of the compare
  assign rd_off   = cmd.srch_step ? cmp_idx + CW'(1) :
                    (kind == KIND_POP_BACK) ? count - CW'(1) : '0;
  assign rd_addr  = ring(front, rd_off);

  cdq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wr_addr),
    .wdata (value),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_comb begin
    stat           = '0;
    stat.is_push   = (kind == KIND_PUSH_FRONT) || (kind == KIND_PUSH_BACK);
    stat.is_pop    = (kind == KIND_POP_FRONT) || (kind == KIND_POP_BACK);
    stat.is_search = (kind == KIND_SEARCH);
    stat.full      = (count == CW'(DEPTH));
    stat.empty     = (count == '0);
    stat.hit       = (rdata == value);
    stat.last      = (cmp_idx == count - CW'(1));
    stat.out_free  = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.push) begin
        count <= count + CW'(1);
        if (kind == KIND_PUSH_FRONT) begin
          front <= front_m1;
        end
      end
      if (cmd.pop_commit) begin
        count <= count - CW'(1);
        if (kind == KIND_POP_FRONT) begin
          front <= ring(front, CW'(1));
        end
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind    <= in_kind;
      value   <= in_value;
      cmp_idx <= '0;
    end
    if (cmd.res_plain) begin
      res_value <= '0;
      res_pos   <= '0;
      if (stat.is_push && stat.full) begin
        res_status <= ST_FULL;
      end else if ((stat.is_pop || stat.is_search) && stat.empty) begin
        res_status <= ST_EMPTY;
      end else begin
        res_status <= ST_OK;
      end
    end
    if (cmd.pop_commit) begin
      res_status <= ST_OK;
      res_value  <= rdata;
      res_pos    <= '0;
    end
    if (cmd.srch_step) begin
      res_value <= '0;
      if (stat.hit) begin
        res_status <= ST_OK;
        res_pos    <= cmp_idx + CW'(1);
      end else begin
        res_status <= ST_NOTFOUND;
        res_pos    <= '0;
        cmp_idx    <= cmp_idx + CW'(1);
      end
    end
    if (cmd.emit) begin
      out_status <= res_status;
      out_value  <= res_value;
      out_pos    <= POS_W'(res_pos);
      out_occ    <= OCC_W'(count);
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_occ, out_pos, out_value};
  assign m_tuser = out_status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> (count == $past(count) + CW'(1)))
    else $error("push did not raise the entry count");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_commit |=> (count == $past(count) - CW'(1)))
    else $error("pop did not lower the entry count");

endmodule

`default_nettype wire

FILE: sv/circular_deque_with_search.sv
// double-ended queue over a ring buffer, with a linear search from the front
//
// usage: each request on the s_ side carries a kind in s_tuser (push front,
// push back, pop front, pop back, search) and a value in s_tdata. exactly one
// result leaves on the m_ side: status in m_tuser, and in m_tdata the popped
// value, the 1-based match position and the occupancy after the request.
// one request is worked on at a time; s_tready is high only while idle.
// a push, a refused request or an unused kind goes straight to its result; a pop
// adds one registered read of the entry store; a search reads the store one
// entry a cycle and stops at the first match or at the last entry. the block
// returns to its idle state after each result, before the next acceptance.
// the result sits in an output register; if the receiver stalls, the block
// finishes the next request and waits in its done state until the register
// drains. reset clears the pointers, the count and the output valid; store
// contents are not cleared and no clearing pass is needed.
`default_nettype none

module circular_deque_with_search
  import cdq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [VALUE_W-1:0]  s_tdata,   // [31:0] value
  input  wire logic [KIND_W-1:0]   s_tuser,   // [2:0] kind
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [TDATA_W-1:0]       m_tdata,   // [31:0] result_value, [36:32] position,
                                              // [41:37] occupancy, [47:42] zero
  output logic [STATUS_W-1:0]      m_tuser    // [1:0] status
);

  cdq_cmd_t  cmd;
  cdq_stat_t stat;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdq_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_kind  (s_tuser),
    .in_value (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
